FILE: rtl/egd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package egd_pkg;

  localparam int unsigned AddrWidth = 5;

  typedef enum logic [2:0] {
    REG_SENSITIVITY  = 3'd0,
    REG_COUNT_THRESH = 3'd1,
    REG_STEP_LOCKOUT = 3'd2,
    REG_BTN_LOCKOUT  = 3'd3,
    REG_IDLE_TIMEOUT = 3'd4
  } reg_idx_e;

  localparam logic [7:0]  SensitivityRst  = 8'd8;
  localparam logic [7:0]  CountThreshRst  = 8'd4;
  localparam logic [11:0] StepLockoutRst  = 12'd250;
  localparam logic [11:0] BtnLockoutRst   = 12'd1000;
  localparam logic [15:0] IdleTimeoutRst  = 16'd5000;
  localparam logic [15:0] IdleMax         = 16'hFFFF;

endpackage

`default_nettype wire

FILE: rtl/encoder_gesture_detector_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Valid        Stall        Word
// poll      in         in_valid_i   in_stall_o   enc_a, enc_b, press_btn_n, reset_btn_n, ms_tick
// result    out        out_valid_o  out_stall_i  cmd_right, cmd_left, cmd_press, cmd_reset, busy_res
// config    in         psel/penable              APB-style, pready tied high
//
// One poll word is accepted every cycle unless stalled; its result word appears in the next cycle.
// The whole detector update is one combinational pass from the state registers
// into the state and result registers.
// A stalled result word holds in the output register and stalls the poll side.
// Reset clears all counters and loads the default register values.

module encoder_gesture_detector_core
  import egd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 enc_a_i,
  input  wire logic                 enc_b_i,
  input  wire logic                 press_btn_n_i,
  input  wire logic                 reset_btn_n_i,
  input  wire logic                 ms_tick_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      cmd_right_o,
  output logic                      cmd_left_o,
  output logic                      cmd_press_o,
  output logic                      cmd_reset_o,
  output logic                      busy_res_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [7:0]  sens_q, thr_q;
  logic [11:0] step_lo_q, btn_lo_q;
  logic [15:0] idle_to_q;

  logic        prev_a_q, prev_a_d;
  logic [7:0]  edges_l_q, edges_l_d, edges_r_q, edges_r_d;
  logic [7:0]  det_l_q, det_l_d, det_r_q, det_r_d;
  logic [7:0]  seen_l_q, seen_l_d, seen_r_q, seen_r_d;
  logic [15:0] idle_q, idle_d;
  logic [13:0] lock_q, lock_d;

  logic        out_valid_q;
  logic        right_q, right_d, left_q, left_d, press_q, press_d, rst_q, rst_d;
  logic        busy_q, busy_d;

  logic        accept;
  logic        cfg_wr;
  reg_idx_e    idx;

  assign pready     = 1'b1;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cfg_wr     = psel && penable && pwrite;
  assign idx        = reg_idx_e'(paddr[AddrWidth-1:2]);

  always_comb begin
    unique case (idx)
      REG_SENSITIVITY:  prdata = {24'd0, sens_q};
      REG_COUNT_THRESH: prdata = {24'd0, thr_q};
      REG_STEP_LOCKOUT: prdata = {20'd0, step_lo_q};
      REG_BTN_LOCKOUT:  prdata = {20'd0, btn_lo_q};
      REG_IDLE_TIMEOUT: prdata = {16'd0, idle_to_q};
      default:          prdata = 32'd0;
    endcase
  end

  always_comb begin
    logic [13:0] add;
    logic [7:0]  el1, er1;
    add       = '0;
    prev_a_d  = prev_a_q;
    edges_l_d = edges_l_q;
    edges_r_d = edges_r_q;
    det_l_d   = det_l_q;
    det_r_d   = det_r_q;
    seen_l_d  = seen_l_q;
    seen_r_d  = seen_r_q;
    lock_d    = lock_q;
    right_d   = 1'b0;
    left_d    = 1'b0;
    press_d   = 1'b0;
    rst_d     = 1'b0;
    busy_d    = 1'b0;
    el1       = edges_l_q + 8'd1;
    er1       = edges_r_q + 8'd1;
    idle_d    = (ms_tick_i && idle_q != IdleMax) ? idle_q + 16'd1 : idle_q;

    if (lock_q != '0) begin
      busy_d = 1'b1;
      if (ms_tick_i) begin
        lock_d = lock_q - 14'd1;
      end
    end else begin
      if (enc_a_i != prev_a_q) begin
        if (enc_b_i != enc_a_i) begin
          edges_l_d = el1;
          edges_r_d = '0;
          if (el1 > sens_q) begin
            det_l_d   = det_l_q + 8'd1;
            edges_l_d = '0;
            add       = add + {2'd0, step_lo_q};
          end
        end else begin
          edges_r_d = er1;
          edges_l_d = '0;
          if (er1 > sens_q) begin
            det_r_d   = det_r_q + 8'd1;
            edges_r_d = '0;
            add       = add + {2'd0, step_lo_q};
          end
        end
      end
      prev_a_d = enc_a_i;

      if (!press_btn_n_i) begin
        press_d = 1'b1;
        add     = add + {2'd0, btn_lo_q};
      end
      if (!reset_btn_n_i) begin
        rst_d = 1'b1;
        add   = add + {2'd0, btn_lo_q};
      end
      if (!press_btn_n_i || !reset_btn_n_i) begin
        det_l_d  = '0;
        det_r_d  = '0;
        seen_l_d = '0;
        seen_r_d = '0;
      end

      if (det_r_d > seen_r_d) begin
        seen_r_d = det_r_d;
        seen_l_d = '0;
        det_l_d  = '0;
        idle_d   = '0;
      end
      if (det_l_d > seen_l_d) begin
        seen_l_d = det_l_d;
        seen_r_d = '0;
        det_r_d  = '0;
        idle_d   = '0;
      end
      if (det_r_d > thr_q) begin
        right_d = 1'b1;
        det_r_d = '0;
      end
      if (det_l_d > thr_q) begin
        left_d  = 1'b1;
        det_l_d = '0;
      end
      if (idle_d > idle_to_q) begin
        det_l_d  = '0;
        det_r_d  = '0;
        seen_l_d = '0;
        seen_r_d = '0;
      end
      lock_d = add;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q      <= SensitivityRst;
      thr_q       <= CountThreshRst;
      step_lo_q   <= StepLockoutRst;
      btn_lo_q    <= BtnLockoutRst;
      idle_to_q   <= IdleTimeoutRst;
      prev_a_q    <= 1'b0;
      edges_l_q   <= '0;
      edges_r_q   <= '0;
      det_l_q     <= '0;
      det_r_q     <= '0;
      seen_l_q    <= '0;
      seen_r_q    <= '0;
      idle_q      <= '0;
      lock_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (idx)
          REG_SENSITIVITY:  sens_q    <= pwdata[7:0];
          REG_COUNT_THRESH: thr_q     <= pwdata[7:0];
          REG_STEP_LOCKOUT: step_lo_q <= pwdata[11:0];
          REG_BTN_LOCKOUT:  btn_lo_q  <= pwdata[11:0];
          REG_IDLE_TIMEOUT: idle_to_q <= pwdata[15:0];
          default: ;
        endcase
      end
      if (accept) begin
        prev_a_q    <= prev_a_d;
        edges_l_q   <= edges_l_d;
        edges_r_q   <= edges_r_d;
        det_l_q     <= det_l_d;
        det_r_q     <= det_r_d;
        seen_l_q    <= seen_l_d;
        seen_r_q    <= seen_r_d;
        idle_q      <= idle_d;
        lock_q      <= lock_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      right_q <= right_d;
      left_q  <= left_d;
      press_q <= press_d;
      rst_q   <= rst_d;
      busy_q  <= busy_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_right_o = right_q;
  assign cmd_left_o  = left_q;
  assign cmd_press_o = press_q;
  assign cmd_reset_o = rst_q;
  assign busy_res_o  = busy_q;

  a_busy_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && busy_res_o |-> !(cmd_right_o || cmd_left_o || cmd_press_o || cmd_reset_o))
    else $error("busy result carries a command");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted poll produced no result");

  a_lockout_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && lock_q != '0 |=> busy_res_o)
    else $error("poll during lockout not marked busy");

  a_button_lockout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && lock_q == '0 && !press_btn_n_i && btn_lo_q != '0 |=> lock_q != '0)
    else $error("press did not start a lockout");

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import egd_pkg::*;

  typedef struct packed {
    logic enc_a;
    logic enc_b;
    logic press_n;
    logic reset_n;
    logic tick;
  } poll_word_t;

  typedef struct packed {
    logic right;
    logic left;
    logic press;
    logic rst;
    logic busy;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0]  sens;
    logic [7:0]  thresh;
    logic [11:0] step_lock;
    logic [11:0] btn_lock;
    logic [15:0] idle_to;
  } gesture_cfg_t;

  typedef struct packed {
    logic        prev_a;
    logic [7:0]  edges_l;
    logic [7:0]  edges_r;
    logic [7:0]  det_l;
    logic [7:0]  det_r;
    logic [7:0]  seen_l;
    logic [7:0]  seen_r;
    logic [15:0] idle_ms;
    logic [13:0] lock_ms;
  } gesture_state_t;

  typedef struct packed {
    poll_word_t poll;
    logic       known;
    cmd_word_t  want;
    logic       drain;
    logic       reconf;
  } directed_row_t;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned PhaseQuota = 100;
  localparam int unsigned SendPct [NumPhases] = '{32, 32, 86, 86, 0, 0};
  localparam int unsigned RecvPct [NumPhases] = '{86, 86, 32, 32, 0, 0};

  localparam gesture_cfg_t DirectedCfg = '{8'd0, 8'd1, 12'd2, 12'd3, 16'd4};
  localparam gesture_cfg_t ZeroCfg = '{8'd0, 8'd0, 12'd0, 12'd0, 16'd0};
  localparam gesture_cfg_t TopCfg = '{8'd254, 8'd254, 12'd4095, 12'd4095, 16'd65534};

  localparam int unsigned NumDirected = 20;
  localparam directed_row_t Directed [NumDirected] = '{
    '{'{1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, 1'b0},
    '{'{1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, 1'b1},
    '{'{1'b0, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, 1'b0},
    '{'{1'b0, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1, 1'b1},
    '{'{1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, 1'b0},
    '{'{1'b1, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1, 1'b0},
    '{'{1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0, 1'b1, 1'b0},
    '{'{1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0, 1'b1, 1'b0},
    '{'{1'b0, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0, 1'b1, 1'b0},
    '{'{1'b1, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, '0, 1'b1, 1'b0},
    '{'{1'b0, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, '0, 1'b1, 1'b0},
    '{'{1'b0, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, '0, 1'b0, 1'b0},
    '{'{1'b0, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, '0, 1'b0, 1'b0},
    '{'{1'b0, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, '0, 1'b0, 1'b0},
    '{'{1'b0, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, '0, 1'b0, 1'b0},
    '{'{1'b1, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0, 1'b1, 1'b0},
    '{'{1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0, 1'b1, 1'b0},
    '{'{1'b1, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0, 1'b1, 1'b0},
    '{'{1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0, 1'b0, 1'b0},
    '{'{1'b0, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b0, '0, 1'b1, 1'b0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 enc_a_i = 1'b0;
  logic                 enc_b_i = 1'b0;
  logic                 press_btn_n_i = 1'b1;
  logic                 reset_btn_n_i = 1'b1;
  logic                 ms_tick_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 cmd_right_o;
  logic                 cmd_left_o;
  logic                 cmd_press_o;
  logic                 cmd_reset_o;
  logic                 busy_res_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  gesture_cfg_t   gcfg;
  gesture_state_t gst;
  cmd_word_t      expected_cmds [$];
  cmd_word_t      oldest_cmd;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned polls_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_right = 0;
  int unsigned n_left = 0;
  int unsigned n_press = 0;
  int unsigned n_reset = 0;
  int unsigned n_ignored = 0;

  encoder_gesture_detector_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .enc_a_i      (enc_a_i),
    .enc_b_i      (enc_b_i),
    .press_btn_n_i(press_btn_n_i),
    .reset_btn_n_i(reset_btn_n_i),
    .ms_tick_i    (ms_tick_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_right_o  (cmd_right_o),
    .cmd_left_o   (cmd_left_o),
    .cmd_press_o  (cmd_press_o),
    .cmd_reset_o  (cmd_reset_o),
    .busy_res_o   (busy_res_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk_i = ~clk_i;

  function automatic cmd_word_t detect_gesture(input poll_word_t p);
    cmd_word_t   r;
    logic [13:0] add;
    r = '0;
    add = '0;
    if (p.tick && gst.idle_ms != IdleMax) gst.idle_ms = gst.idle_ms + 16'd1;
    if (gst.lock_ms != '0) begin
      if (p.tick) gst.lock_ms = gst.lock_ms - 14'd1;
      r.busy = 1'b1;
      return r;
    end
    if (p.enc_a != gst.prev_a) begin
      if (p.enc_b != p.enc_a) begin
        gst.edges_l = gst.edges_l + 8'd1;
        gst.edges_r = '0;
        if (gst.edges_l > gcfg.sens) begin
          gst.det_l = gst.det_l + 8'd1;
          gst.edges_l = '0;
          add = add + 14'(gcfg.step_lock);
        end
      end else begin
        gst.edges_r = gst.edges_r + 8'd1;
        gst.edges_l = '0;
        if (gst.edges_r > gcfg.sens) begin
          gst.det_r = gst.det_r + 8'd1;
          gst.edges_r = '0;
          add = add + 14'(gcfg.step_lock);
        end
      end
    end
    gst.prev_a = p.enc_a;
    if (!p.press_n) r.press = 1'b1;
    if (!p.reset_n) r.rst = 1'b1;
    if (r.press || r.rst) begin
      gst.det_l = '0;
      gst.det_r = '0;
      gst.seen_l = '0;
      gst.seen_r = '0;
      if (r.press) add = add + 14'(gcfg.btn_lock);
      if (r.rst) add = add + 14'(gcfg.btn_lock);
    end
    if (gst.det_r > gst.seen_r) begin
      gst.seen_r = gst.det_r;
      gst.seen_l = '0;
      gst.det_l = '0;
      gst.idle_ms = '0;
    end
    if (gst.det_l > gst.seen_l) begin
      gst.seen_l = gst.det_l;
      gst.seen_r = '0;
      gst.det_r = '0;
      gst.idle_ms = '0;
    end
    if (gst.det_r > gcfg.thresh) begin
      r.right = 1'b1;
      gst.det_r = '0;
    end
    if (gst.det_l > gcfg.thresh) begin
      r.left = 1'b1;
      gst.det_l = '0;
    end
    if (gst.idle_ms > gcfg.idle_to) begin
      gst.det_l = '0;
      gst.det_r = '0;
      gst.seen_l = '0;
      gst.seen_r = '0;
    end
    gst.lock_ms = gst.lock_ms + add;
    return r;
  endfunction

  function automatic void check_bit(input string name, input logic want, input logic got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0b, got %0b", $time, name, want, got);
    end
  endfunction

  task automatic send_poll(input poll_word_t p, output cmd_word_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    enc_a_i <= p.enc_a;
    enc_b_i <= p.enc_b;
    press_btn_n_i <= p.press_n;
    reset_btn_n_i <= p.reset_n;
    ms_tick_i <= p.tick;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = detect_gesture(p);
    expected_cmds.push_back(r);
    polls_sent++;
  endtask

  task automatic drain_lockout();
    poll_word_t p;
    cmd_word_t  r;
    while (gst.lock_ms != '0) begin
      p = poll_word_t'(5'($urandom_range(31)));
      p.tick = 1'b1;
      send_poll(p, r);
    end
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_config(input gesture_cfg_t c);
    reg_idx_e    idx;
    logic [31:0] val;
    idx = REG_SENSITIVITY;
    repeat (5) begin
      case (idx)
        REG_SENSITIVITY:  val = 32'(c.sens);
        REG_COUNT_THRESH: val = 32'(c.thresh);
        REG_STEP_LOCKOUT: val = 32'(c.step_lock);
        REG_BTN_LOCKOUT:  val = 32'(c.btn_lock);
        REG_IDLE_TIMEOUT: val = 32'(c.idle_to);
        default:          val = '0;
      endcase
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      idx = idx.next();
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    gcfg = c;
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned counted;
    int unsigned len;
    logic        dir_right;
    poll_word_t  p;
    cmd_word_t   r;
    counted = 0;
    while (counted < quota) begin
      if ($urandom_range(3) != 0) begin
        dir_right = 1'($urandom_range(1));
        len = $urandom_range(1, 24);
        repeat (len) begin
          if ($urandom_range(9) == 0) dir_right = ~dir_right;
          p.enc_a = ($urandom_range(5) == 0) ? gst.prev_a : ~gst.prev_a;
          p.enc_b = dir_right ? p.enc_a : ~p.enc_a;
          p.press_n = ($urandom_range(40) != 0);
          p.reset_n = ($urandom_range(40) != 0);
          p.tick = 1'($urandom_range(1));
          send_poll(p, r);
          counted++;
        end
      end else begin
        p = poll_word_t'(5'($urandom_range(31)));
        if ($urandom_range(2) != 0) begin
          p.press_n = 1'b1;
          p.reset_n = 1'b1;
        end
        send_poll(p, r);
        counted++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_reqs != hold_done) begin
      hold_done = hold_reqs;
      hold_left = 48;
    end
    if (hold_left != 0) hold_left--;
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_cmds.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected", $time);
      end else begin
        oldest_cmd = expected_cmds.pop_front();
        check_bit("cmd_right", oldest_cmd.right, cmd_right_o);
        check_bit("cmd_left", oldest_cmd.left, cmd_left_o);
        check_bit("cmd_press", oldest_cmd.press, cmd_press_o);
        check_bit("cmd_reset", oldest_cmd.rst, cmd_reset_o);
        check_bit("busy_res", oldest_cmd.busy, busy_res_o);
        n_checked++;
        if (oldest_cmd.right) n_right++;
        if (oldest_cmd.left) n_left++;
        if (oldest_cmd.press) n_press++;
        if (oldest_cmd.rst) n_reset++;
        if (oldest_cmd.busy) n_ignored++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    poll_word_t    p;
    cmd_word_t     r;
    directed_row_t row;
    gesture_cfg_t  c;
    gcfg = '{SensitivityRst, CountThreshRst, StepLockoutRst, BtnLockoutRst, IdleTimeoutRst};
    gst = '0;
    send_idle_pct = SendPct[0];
    recv_idle_pct = RecvPct[0];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      row = Directed[i];
      send_poll(row.poll, r);
      if (row.known) expected_cmds[$] = row.want;
      if (row.drain) drain_lockout();
      if (row.reconf) begin
        quiesce();
        load_config(DirectedCfg);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      quiesce();
      if (ph == 1) begin
        c = ZeroCfg;
      end else begin
        c.sens = 8'($urandom_range(0, 3));
        c.thresh = 8'($urandom_range(0, 3));
        c.step_lock = 12'($urandom_range(0, 6));
        c.btn_lock = 12'($urandom_range(0, 10));
        c.idle_to = 16'($urandom_range(0, 40));
      end
      load_config(c);
      send_idle_pct = SendPct[ph];
      recv_idle_pct = RecvPct[ph];
      if (ph >= 4) hold_reqs++;
      random_phase(PhaseQuota);
    end

    // Slowest settings: the widest edge count gives one detent, and together with both
    // buttons in the same word it stacks all lockouts into the largest lockout sum.
    quiesce();
    load_config(TopCfg);
    for (int k = 0; k < 255; k++) begin
      p.enc_a = ~gst.prev_a;
      p.enc_b = p.enc_a;
      p.press_n = (k != 254);
      p.reset_n = (k != 254);
      p.tick = 1'b0;
      send_poll(p, r);
    end
    p = '{gst.prev_a, 1'b0, 1'b1, 1'b1, 1'b1};
    repeat (8) send_poll(p, r);

    quiesce();
    $display("tb: %0d words checked of %0d sent, %0d ignored in lockout", n_checked,
             polls_sent, n_ignored);
    $display("tb: commands seen: %0d right, %0d left, %0d press, %0d reset", n_right, n_left,
             n_press, n_reset);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/egd_pkg.sv
rtl/encoder_gesture_detector_core.sv
verif/tb.sv
